FILE: hw/rtl/rpt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Route table package
// Shared types, sizes and codes of the IPv4 priority route table.
// ----------------------------------------------------------------------------
package rpt_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int INTF_COUNT  = 8;
  localparam int QUEUE_DEPTH = 2;

  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    OP_ADD    = 1'b0,
    OP_LOOKUP = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_ADDED   = 2'd0,
    ST_FULL    = 2'd1,
    ST_FOUND   = 2'd2,
    ST_NOROUTE = 2'd3
  } status_e;

  // One classified request as it travels from the front end to the table.
  typedef struct packed {
    op_e         op;
    logic [31:0] dst;
    logic [31:0] mask;
    logic [31:0] gw;
    logic [2:0]  intf;
  } req_t;

  // Interface indexes at or above the interface count are clamped to the last one.
  function automatic logic [2:0] sat_intf(logic [2:0] intf);
    logic [2:0] res;
    res = intf;
    if (int'(intf) >= INTF_COUNT) begin
      res = 3'(INTF_COUNT - 1);
    end
    return res;
  endfunction

endpackage

FILE: hw/rtl/rpt_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Route table front end
// Registers incoming items, decodes the request type and clamps the interface.
// ----------------------------------------------------------------------------
module rpt_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             req_type_i,
  input  logic [31:0]      dst_addr_i,
  input  logic [31:0]      net_mask_i,
  input  logic [31:0]      gateway_addr_i,
  input  logic [2:0]       intf_id_i,
  output logic             push_o,
  output rpt_pkg::req_t    push_req_o,
  input  logic             q_full_i
);

  logic          valid_q;
  logic          valid_d;
  rpt_pkg::req_t req_q;
  logic          take;

  assign push_o     = valid_q && !q_full_i;
  assign in_stall_o = valid_q && q_full_i;
  assign take       = in_valid_i && !in_stall_o;
  assign push_req_o = req_q;

  always_comb begin
    valid_d = valid_q;
    if (push_o) begin
      valid_d = 1'b0;
    end
    if (take) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      req_q.op   <= rpt_pkg::op_e'(req_type_i);
      req_q.dst  <= dst_addr_i;
      req_q.mask <= net_mask_i;
      req_q.gw   <= gateway_addr_i;
      req_q.intf <= rpt_pkg::sat_intf(intf_id_i);
    end
  end

endmodule

FILE: hw/rtl/rpt_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Route table request queue
// Short FIFO that decouples the front end from the table engine.
// ----------------------------------------------------------------------------
module rpt_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  rpt_pkg::req_t push_req_i,
  output logic          full_o,
  output logic          not_empty_o,
  output rpt_pkg::req_t head_o,
  input  logic          pop_i
);

  rpt_pkg::req_t               slot_q [rpt_pkg::QUEUE_DEPTH];
  logic [rpt_pkg::QPTR_W-1:0]  wr_ptr_q;
  logic [rpt_pkg::QPTR_W-1:0]  wr_ptr_d;
  logic [rpt_pkg::QPTR_W-1:0]  rd_ptr_q;
  logic [rpt_pkg::QPTR_W-1:0]  rd_ptr_d;
  logic [rpt_pkg::QCNT_W-1:0]  cnt_q;
  logic [rpt_pkg::QCNT_W-1:0]  cnt_d;
  logic                        do_push;
  logic                        do_pop;

  function automatic logic [rpt_pkg::QPTR_W-1:0] wrap_inc(
    logic [rpt_pkg::QPTR_W-1:0] ptr
  );
    logic [rpt_pkg::QPTR_W-1:0] res;
    if (int'(ptr) == rpt_pkg::QUEUE_DEPTH - 1) begin
      res = '0;
    end else begin
      res = ptr + 1'b1;
    end
    return res;
  endfunction

  assign full_o      = (cnt_q == rpt_pkg::QCNT_W'(rpt_pkg::QUEUE_DEPTH));
  assign not_empty_o = (cnt_q != '0);
  assign head_o      = slot_q[rd_ptr_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_i && not_empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = wrap_inc(wr_ptr_q);
    end
    if (do_pop) begin
      rd_ptr_d = wrap_inc(rd_ptr_q);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_req_i;
    end
  end

endmodule

FILE: hw/rtl/rpt_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Route table engine
// Row of route cells kept in descending mask order, with a parallel lookup
// and an insert that shifts the lower-priority cells down by one.
// ----------------------------------------------------------------------------
module rpt_engine (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          not_empty_i,
  input  rpt_pkg::req_t head_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [1:0]    status_o,
  output logic [31:0]   next_hop_o,
  output logic [2:0]    out_intf_o,
  output logic          on_link_o
);

  localparam int D = rpt_pkg::TABLE_DEPTH;

  logic [31:0]               dest_q [D];
  logic [31:0]               mask_q [D];
  logic [31:0]               gw_q   [D];
  logic [2:0]                intf_q [D];
  logic [rpt_pkg::CNT_W-1:0] count_q;
  logic [rpt_pkg::CNT_W-1:0] count_d;

  logic [D-1:0] used;
  logic [D-1:0] ge;
  logic [D-1:0] hit;
  logic [D-1:0] load_new;
  logic [D-1:0] load_prev;
  logic         table_full;
  logic         do_insert;

  logic         found;
  logic [31:0]  sel_gw;
  logic [2:0]   sel_intf;

  logic              out_valid_q;
  logic              out_valid_d;
  rpt_pkg::status_e  status_q;
  rpt_pkg::status_e  status_d;
  logic [31:0]       next_hop_q;
  logic [31:0]       next_hop_d;
  logic [2:0]        out_intf_q;
  logic [2:0]        out_intf_d;
  logic              on_link_q;
  logic              on_link_d;
  logic              order_ok;

  assign pop_o       = not_empty_i && (!out_valid_q || !out_stall_i);
  assign table_full  = (count_q == rpt_pkg::CNT_W'(D));
  assign do_insert   = pop_o && (head_i.op == rpt_pkg::OP_ADD) && !table_full;

  // Per-cell compare: occupancy, mask ordering against the new route, and match.
  always_comb begin
    for (int k = 0; k < D; k++) begin
      used[k] = (rpt_pkg::CNT_W'(k) < count_q);
      ge[k]   = used[k] && (mask_q[k] >= head_i.mask);
      hit[k]  = used[k] && ((head_i.dst & mask_q[k]) == dest_q[k]);
    end
  end

  // Because masks are in descending order, ge is a run of ones from cell zero.
  // The new route goes into the first cell past that run; cells below it shift.
  always_comb begin
    for (int k = 0; k < D; k++) begin
      if (k == 0) begin
        load_new[k]  = !ge[k];
        load_prev[k] = 1'b0;
      end else begin
        load_new[k]  = ge[k-1] && !ge[k];
        load_prev[k] = used[k-1] && !ge[k-1];
      end
    end
  end

  // The first matching cell in table order wins.
  always_comb begin
    found    = 1'b0;
    sel_gw   = '0;
    sel_intf = '0;
    for (int k = D - 1; k >= 0; k--) begin
      if (hit[k]) begin
        found    = 1'b1;
        sel_gw   = gw_q[k];
        sel_intf = intf_q[k];
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (do_insert) begin
      count_d = count_q + 1'b1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    status_d    = status_q;
    next_hop_d  = next_hop_q;
    out_intf_d  = out_intf_q;
    on_link_d   = on_link_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (pop_o) begin
      out_valid_d = 1'b1;
      next_hop_d  = '0;
      out_intf_d  = '0;
      on_link_d   = 1'b0;
      unique case (head_i.op)
        rpt_pkg::OP_ADD: begin
          if (table_full) begin
            status_d = rpt_pkg::ST_FULL;
          end else begin
            status_d = rpt_pkg::ST_ADDED;
          end
        end
        rpt_pkg::OP_LOOKUP: begin
          if (found) begin
            status_d   = rpt_pkg::ST_FOUND;
            next_hop_d = (sel_gw == '0) ? head_i.dst : sel_gw;
            out_intf_d = sel_intf;
            on_link_d  = (sel_gw == '0);
          end else begin
            status_d = rpt_pkg::ST_NOROUTE;
          end
        end
        default: begin
          status_d = rpt_pkg::ST_NOROUTE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q   <= status_d;
    next_hop_q <= next_hop_d;
    out_intf_q <= out_intf_d;
    on_link_q  <= on_link_d;
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < D; k++) begin
      if (do_insert) begin
        if (load_new[k]) begin
          dest_q[k] <= head_i.dst;
          mask_q[k] <= head_i.mask;
          gw_q[k]   <= head_i.gw;
          intf_q[k] <= head_i.intf;
        end else if (load_prev[k] && k > 0) begin
          dest_q[k] <= dest_q[(k > 0) ? k - 1 : 0];
          mask_q[k] <= mask_q[(k > 0) ? k - 1 : 0];
          gw_q[k]   <= gw_q[(k > 0) ? k - 1 : 0];
          intf_q[k] <= intf_q[(k > 0) ? k - 1 : 0];
        end
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign next_hop_o  = next_hop_q;
  assign out_intf_o  = out_intf_q;
  assign on_link_o   = on_link_q;

  always_comb begin
    order_ok = 1'b1;
    for (int k = 1; k < D; k++) begin
      if (used[k] && (mask_q[k-1] < mask_q[k])) begin
        order_ok = 1'b0;
      end
    end
  end

  // The stored routes must stay sorted by descending mask.
  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni) order_ok)
    else $error("route cells out of mask order");

  // The route count never runs past the table depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= rpt_pkg::CNT_W'(D))
    else $error("route count exceeds table depth");

  // A successful add grows the table by exactly one route.
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_insert |=> (count_q == $past(count_q) + 1'b1))
    else $error("route count did not advance on insert");

  // Anything but a found route carries zero next hop, interface and link flag.
  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (status_q != rpt_pkg::ST_FOUND)) |->
      (next_hop_q == '0 && out_intf_q == '0 && !on_link_q))
    else $error("non-found result carries route fields");

  // An add to a full table gives a full result.
  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && head_i.op == rpt_pkg::OP_ADD && table_full) |=>
      (status_q == rpt_pkg::ST_FULL))
    else $error("full table did not report full");

endmodule

FILE: hw/rtl/ipv4_priority_route_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv4 priority route table
// Route table of TABLE_DEPTH entries kept in descending mask order; add requests
// insert a route unless the table is full, lookup requests return the first matching route.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                 payload
//  in       input      in_valid_i / in_stall_o   req_type, dst_addr, net_mask,
//                                                gateway_addr, intf_id
//  out      output     out_valid_o / out_stall_i status, next_hop, out_intf,
//                                                on_link
//
// An accepted item passes through the input register of the front end, the
// request queue and the result register of the table engine, in that order.
// One item per cycle is sustained while out_stall_i stays low; the compare over
// all route cells is combinational. Reset empties the table and all stages at once.
// A stalled result holds, the queue fills behind it, then in_stall_o rises.
// ----------------------------------------------------------------------------
module ipv4_priority_route_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        req_type_i,
  input  logic [31:0] dst_addr_i,
  input  logic [31:0] net_mask_i,
  input  logic [31:0] gateway_addr_i,
  input  logic [2:0]  intf_id_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [31:0] next_hop_o,
  output logic [2:0]  out_intf_o,
  output logic        on_link_o
);

  logic          push;
  rpt_pkg::req_t push_req;
  logic          q_full;
  logic          q_not_empty;
  rpt_pkg::req_t q_head;
  logic          pop;

  rpt_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .dst_addr_i     (dst_addr_i),
    .net_mask_i     (net_mask_i),
    .gateway_addr_i (gateway_addr_i),
    .intf_id_i      (intf_id_i),
    .push_o         (push),
    .push_req_o     (push_req),
    .q_full_i       (q_full)
  );

  rpt_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_req_i  (push_req),
    .full_o      (q_full),
    .not_empty_o (q_not_empty),
    .head_o      (q_head),
    .pop_i       (pop)
  );

  rpt_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .not_empty_i (q_not_empty),
    .head_i      (q_head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .next_hop_o  (next_hop_o),
    .out_intf_o  (out_intf_o),
    .on_link_o   (on_link_o)
  );

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv4 priority route table testbench
// Drives add and lookup requests with bursty input and a receiver that stalls
// at random. Each accepted request is run through a route table predictor kept
// in the testbench, and every result is checked field by field in order.
// ----------------------------------------------------------------------------
module testbench;

  localparam int HOLD_CYCLES = 250;

  typedef struct packed {
    rpt_pkg::status_e status;
    logic [31:0]      next_hop;
    logic [2:0]       intf;
    logic             on_link;
  } route_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        req_type_i;
  logic [31:0] dst_addr_i;
  logic [31:0] net_mask_i;
  logic [31:0] gateway_addr_i;
  logic [2:0]  intf_id_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [1:0]  status_o;
  logic [31:0] next_hop_o;
  logic [2:0]  out_intf_o;
  logic        on_link_o;

  ipv4_priority_route_table dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .dst_addr_i     (dst_addr_i),
    .net_mask_i     (net_mask_i),
    .gateway_addr_i (gateway_addr_i),
    .intf_id_i      (intf_id_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .next_hop_o     (next_hop_o),
    .out_intf_o     (out_intf_o),
    .on_link_o      (on_link_o)
  );

  // Predicted table contents, in lookup order.
  logic [31:0] rt_dest[rpt_pkg::TABLE_DEPTH];
  logic [31:0] rt_mask[rpt_pkg::TABLE_DEPTH];
  logic [31:0] rt_gw[rpt_pkg::TABLE_DEPTH];
  logic [2:0]  rt_intf[rpt_pkg::TABLE_DEPTH];
  int          route_cnt;

  // Routes the generator knows will be stored, used to aim lookups at them.
  logic [31:0] plan_dest[rpt_pkg::TABLE_DEPTH];
  logic [31:0] plan_mask[rpt_pkg::TABLE_DEPTH];
  int          plan_n;

  rpt_pkg::req_t pending_reqs[$];
  route_result_t expected_routes[$];

  int err_count;
  int items_taken;
  int n_add, n_lookup, n_added, n_full, n_found, n_noroute;
  int in_stall_cycles;
  bit in_taken;
  bit hold_off;
  int burst_left, gap_left;
  int stall_mode, stall_phase_left;

  initial begin
    clk_i = 1'b0;
  end

  always begin
    #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    err_count++;
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  // Applies one request to the predicted table and queues the result it must give.
  function automatic void route_decide(rpt_pkg::req_t r);
    route_result_t res;
    int pos;
    bit hit;
    res.status   = rpt_pkg::ST_NOROUTE;
    res.next_hop = '0;
    res.intf     = '0;
    res.on_link  = 1'b0;
    hit = 1'b0;
    if (r.op == rpt_pkg::OP_ADD) begin
      n_add++;
      if (route_cnt >= rpt_pkg::TABLE_DEPTH) begin
        res.status = rpt_pkg::ST_FULL;
      end else begin
        // Equal masks keep their order, so the older route stays in front.
        pos = 0;
        while (pos < route_cnt && rt_mask[pos] >= r.mask) pos++;
        for (int k = route_cnt; k > pos; k--) begin
          rt_dest[k] = rt_dest[k-1];
          rt_mask[k] = rt_mask[k-1];
          rt_gw[k]   = rt_gw[k-1];
          rt_intf[k] = rt_intf[k-1];
        end
        rt_dest[pos] = r.dst;
        rt_mask[pos] = r.mask;
        rt_gw[pos]   = r.gw;
        rt_intf[pos] = (int'(r.intf) >= rpt_pkg::INTF_COUNT) ?
                       3'(rpt_pkg::INTF_COUNT - 1) : r.intf;
        route_cnt++;
        res.status = rpt_pkg::ST_ADDED;
      end
    end else begin
      n_lookup++;
      for (int k = 0; k < route_cnt; k++) begin
        if (!hit && ((r.dst & rt_mask[k]) == rt_dest[k])) begin
          hit          = 1'b1;
          res.status   = rpt_pkg::ST_FOUND;
          res.on_link  = (rt_gw[k] == '0);
          res.next_hop = res.on_link ? r.dst : rt_gw[k];
          res.intf     = rt_intf[k];
        end
      end
    end
    expected_routes.push_back(res);
  endfunction

  task automatic queue_add(input logic [31:0] dst, input logic [31:0] mask,
                           input logic [31:0] gw, input logic [2:0] intf);
    rpt_pkg::req_t r;
    r.op   = rpt_pkg::OP_ADD;
    r.dst  = dst;
    r.mask = mask;
    r.gw   = gw;
    r.intf = intf;
    pending_reqs.push_back(r);
    if (plan_n < rpt_pkg::TABLE_DEPTH) begin
      plan_dest[plan_n] = dst;
      plan_mask[plan_n] = mask;
      plan_n++;
    end
  endtask

  // The mask, gateway and interface of a lookup are don't-care, so they get noise.
  task automatic queue_lookup(input logic [31:0] addr);
    rpt_pkg::req_t r;
    r.op   = rpt_pkg::OP_LOOKUP;
    r.dst  = addr;
    r.mask = $urandom;
    r.gw   = $urandom;
    r.intf = 3'($urandom_range(0, 7));
    pending_reqs.push_back(r);
  endtask

  task automatic build_random_items(input int count);
    int idx;
    int plen;
    int pick;
    logic [31:0] m;
    logic [31:0] d;
    logic [31:0] g;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) < 8) begin
        pick = $urandom_range(0, 9);
        if (pick < 5) begin
          plen = $urandom_range(1, 32);
          m = 32'hFFFF_FFFF << (32 - plen);
        end else if (pick < 8 || plan_n == 0) begin
          m = $urandom;
        end else begin
          m = plan_mask[$urandom_range(0, plan_n - 1)];
        end
        d = $urandom;
        if ($urandom_range(0, 99) < 85) d = d & m;
        g = ($urandom_range(0, 9) < 3) ? 32'h0 : 32'($urandom);
        queue_add(d, m, g, 3'($urandom_range(0, 7)));
      end else if (plan_n > 0 && $urandom_range(0, 9) < 7) begin
        idx = $urandom_range(0, plan_n - 1);
        queue_lookup((plan_dest[idx] & plan_mask[idx]) | (32'($urandom) & ~plan_mask[idx]));
      end else begin
        queue_lookup($urandom);
      end
    end
  endtask

  // Sender: bursts of random length separated by random gaps.
  always @(negedge clk_i) begin
    rpt_pkg::req_t nxt;
    if (rst_ni && !(in_valid_i && !in_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (pending_reqs.size() == 0) begin
        in_valid_i <= 1'b0;
      end else begin
        nxt = pending_reqs.pop_front();
        req_type_i     <= nxt.op;
        dst_addr_i     <= nxt.dst;
        net_mask_i     <= nxt.mask;
        gateway_addr_i <= nxt.gw;
        intf_id_i      <= nxt.intf;
        in_valid_i     <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
      in_taken = 1'b0;
    end
  end

  // Receiver: stall pattern that changes density from phase to phase.
  always @(negedge clk_i) begin
    bit s;
    if (stall_phase_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_phase_left = $urandom_range(20, 150);
    end else begin
      stall_phase_left--;
    end
    case (stall_mode)
      0: s = 1'b0;
      1: s = ($urandom_range(0, 3) == 0);
      2: s = $urandom_range(0, 1);
      default: s = ($urandom_range(0, 9) < 8);
    endcase
    out_stall_i <= hold_off || s;
  end

  // Long receiver hold-off so the request queue fills and the input stalls.
  initial begin
    hold_off = 1'b0;
    wait (items_taken >= 300);
    @(posedge clk_i);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_off = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i) begin
      if (!in_stall_o) begin
        route_decide('{op: rpt_pkg::op_e'(req_type_i), dst: dst_addr_i, mask: net_mask_i,
                       gw: gateway_addr_i, intf: intf_id_i});
        in_taken = 1'b1;
        items_taken++;
      end else begin
        in_stall_cycles++;
      end
    end
  end

  always @(posedge clk_i) begin
    route_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_routes.size() == 0) begin
        report_mismatch("result with no request pending", 32'(status_o), '0);
      end else begin
        want = expected_routes.pop_front();
        case (want.status)
          rpt_pkg::ST_ADDED: n_added++;
          rpt_pkg::ST_FULL:  n_full++;
          rpt_pkg::ST_FOUND: n_found++;
          default:           n_noroute++;
        endcase
        if (status_o !== want.status)
          report_mismatch("status", 32'(status_o), 32'(want.status));
        if (next_hop_o !== want.next_hop)
          report_mismatch("next_hop", next_hop_o, want.next_hop);
        if (out_intf_o !== want.intf)
          report_mismatch("out_intf", 32'(out_intf_o), 32'(want.intf));
        if (on_link_o !== want.on_link)
          report_mismatch("on_link", 32'(on_link_o), 32'(want.on_link));
      end
    end
  end

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    req_type_i     = 1'b0;
    dst_addr_i     = '0;
    net_mask_i     = '0;
    gateway_addr_i = '0;
    intf_id_i      = '0;
    out_stall_i    = 1'b0;
    in_taken       = 1'b0;
    burst_left     = 0;
    gap_left       = 0;
    stall_mode     = 0;
    stall_phase_left = 0;
    route_cnt      = 0;
    plan_n         = 0;
    err_count      = 0;
    items_taken    = 0;

    // Empty table: both address extremes find nothing.
    queue_lookup(32'h0000_0000);
    queue_lookup(32'hFFFF_FFFF);
    queue_add(32'h0A00_0000, 32'hFF00_0000, 32'hC0A8_0001, 3'd1);
    queue_add(32'h0A01_0000, 32'hFFFF_0000, 32'h0000_0000, 3'd2);
    // Same prefix again: the earlier on-link route keeps priority.
    queue_add(32'h0A01_0000, 32'hFFFF_0000, 32'h0A00_00FE, 3'd3);
    queue_add(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd7);
    // Destination outside a zero mask, so this route can never match.
    queue_add(32'h0000_0001, 32'h0000_0000, 32'h1234_5678, 3'd5);
    queue_add(32'hC0A8_0000, 32'hFFFF_FF00, 32'h0000_0000, 3'd0);
    queue_add(32'h0000_0005, 32'h0000_000F, 32'h0102_0304, 3'd6);
    queue_lookup(32'h0A01_0203);
    queue_lookup(32'h0A02_0304);
    queue_lookup(32'hFFFF_FFFF);
    queue_lookup(32'h0000_0001);
    queue_lookup(32'h0000_0000);
    queue_lookup(32'h1234_5675);
    queue_lookup(32'hC0A8_00FF);
    queue_lookup(32'h0AFF_FFFF);
    build_random_items(1150);

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_reqs.size() != 0 || in_valid_i) @(posedge clk_i);
    while (expected_routes.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Covered %0d requests: %0d adds (%0d stored, %0d refused as full), %0d lookups",
             items_taken, n_add, n_added, n_full, n_lookup);
    $display("Lookups: %0d found, %0d without route; input stalled %0d cycles",
             n_found, n_noroute, in_stall_cycles);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout: %0d results still outstanding", expected_routes.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/rpt_pkg.sv
hw/rtl/rpt_front.sv
hw/rtl/rpt_queue.sv
hw/rtl/rpt_engine.sv
hw/rtl/ipv4_priority_route_table.sv
test/testbench.sv
